[rtl/vlra_pkg.sv]
package vlra_pkg;

  localparam int LEN_W   = 16;  // payload length field
  localparam int TOTAL_W = 16;  // stored size field, header value
  localparam int START_W = 10;  // reported start block field
  localparam int NUM_W   = 17;  // payload plus header bytes before the range check
  localparam int NEED_W  = 16;  // block count of one message
  localparam int CMP_W   = 17;  // common width for block count against free count
  localparam int SUM_W   = 18;  // block index plus block count

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_PEEK = 2'd2
  } func_t;

  localparam logic [TOTAL_W-1:0] HDR_EMPTY = 16'd0;  // terminator
  localparam logic [TOTAL_W-1:0] HDR_WRAP  = 16'd1;  // reader goes back to block 0

endpackage

[rtl/vlra_if.sv]
interface vlra_in_if import vlra_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       func;
  logic [LEN_W-1:0] payload_len;

  modport source (output valid, output func, output payload_len, input ready);
  modport sink   (input valid, input func, input payload_len, output ready);
endinterface

interface vlra_out_if import vlra_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               ok;
  logic [START_W-1:0] start_block;
  logic [TOTAL_W-1:0] total_bytes;

  modport source (output valid, output ok, output start_block, output total_bytes, input ready);
  modport sink   (input valid, input ok, input start_block, input total_bytes, output ready);
endinterface

[rtl/variable_length_ring_allocator_top.sv]
// Channel   Dir  Words                          Handshake
// in_chan   in   func, payload_len              valid/ready
// out_chan  out  ok, start_block, total_bytes   valid/ready, registered
//
// One item at a time through a sequencer around a single-port header memory.
// Push: S_CALC, S_FREE, S_TERM, S_HEAD, S_RESP; a cache refresh adds S_FIT,
// a writer wrap S_WRAPCHK and S_WMARK. Peek: S_FRONT, S_HDR, S_RESP; pop adds
// S_CALC, S_PADV; a wrap marker repeats S_FRONT, S_HDR. The next word is
// accepted the cycle after the result is registered, even while out_chan is
// stalled; a result waits only while the output register is full. After reset
// the header memory is cleared, one entry a cycle, with in_chan.ready low.
module variable_length_ring_allocator_top import vlra_pkg::*; #(
  parameter int BLOCKS      = 1024,
  parameter int BLOCK_BYTES = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  vlra_in_if.sink       in_chan,
  vlra_out_if.source    out_chan
);

  localparam int IDX_W = $clog2(BLOCKS);
  localparam int CNT_W = $clog2(BLOCKS + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CALC, S_FREE, S_WRAPCHK, S_WMARK, S_FIT,
    S_TERM, S_HEAD, S_FRONT, S_HDR, S_PADV, S_RESP
  } state_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   addr;
    logic [TOTAL_W-1:0] wdata;
  } mem_ctl_t;

  state_t               state_r;
  logic [IDX_W-1:0]     clr_r;
  logic [1:0]           op_r;
  logic [NUM_W-1:0]     total_r;
  logic [IDX_W-1:0]     wp_r;
  logic [IDX_W-1:0]     rp_r;
  logic [CNT_W-1:0]     free_r;
  logic [IDX_W-1:0]     end_r;
  logic                 rewound_r;
  logic                 res_ok_r;
  logic [IDX_W-1:0]     res_start_r;
  logic [TOTAL_W-1:0]   res_total_r;
  logic                 out_valid_r;
  logic                 out_ok_r;
  logic [START_W-1:0]   out_start_r;
  logic [TOTAL_W-1:0]   out_total_r;
  logic [TOTAL_W-1:0]   rd_r;
  logic [TOTAL_W-1:0]   hdr_mem [BLOCKS];

  mem_ctl_t             mem_c;
  logic [NEED_W-1:0]    need;
  logic [CMP_W-1:0]     need_c;
  logic [CMP_W-1:0]     free_c;
  logic                 wrap_go;
  logic [SUM_W-1:0]     end_sum;
  logic [IDX_W-1:0]     end_idx;
  logic [SUM_W-1:0]     adv_sum;
  logic [IDX_W-1:0]     adv_idx;
  logic [IDX_W+START_W-1:0] res_start_wide;
  logic                 in_ready;

  vlra_blk_div #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_blk_div (
    .clk   (clk),
    .en    (state_r == S_CALC),
    .total (total_r),
    .need  (need)
  );

  assign need_c  = CMP_W'(need);
  assign free_c  = CMP_W'(free_r);
  assign wrap_go = (need_c >= free_c) && (rp_r != '0);

  // positions of an accepted message always stay inside the ring
  assign end_sum = SUM_W'(wp_r) + SUM_W'(need);
  assign end_idx = (end_sum >= SUM_W'(BLOCKS)) ? IDX_W'(end_sum - SUM_W'(BLOCKS))
                                               : IDX_W'(end_sum);
  assign adv_sum = SUM_W'(rp_r) + SUM_W'(need);
  assign adv_idx = (adv_sum >= SUM_W'(BLOCKS)) ? IDX_W'(adv_sum - SUM_W'(BLOCKS))
                                               : IDX_W'(adv_sum);

  assign res_start_wide = (IDX_W + START_W)'(res_start_r);

  always_comb begin
    mem_c.we    = 1'b0;
    mem_c.addr  = rp_r;
    mem_c.wdata = HDR_EMPTY;
    unique case (state_r)
      S_CLEAR: begin
        mem_c.we   = 1'b1;
        mem_c.addr = clr_r;
      end
      S_WRAPCHK: begin
        mem_c.we   = wrap_go;
        mem_c.addr = '0;
      end
      S_WMARK: begin
        mem_c.we    = 1'b1;
        mem_c.addr  = wp_r;
        mem_c.wdata = HDR_WRAP;
      end
      S_TERM: begin
        mem_c.we   = 1'b1;
        mem_c.addr = end_idx;
      end
      S_HEAD: begin
        mem_c.we    = 1'b1;
        mem_c.addr  = wp_r;
        mem_c.wdata = total_r[TOTAL_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_c.we) begin
      hdr_mem[mem_c.addr] <= mem_c.wdata;
    end
    rd_r <= hdr_mem[mem_c.addr];
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      wp_r        <= '0;
      rp_r        <= '0;
      free_r      <= CNT_W'(BLOCKS);
      rewound_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_RESP the output register is reloaded below instead
      if (out_valid_r && out_chan.ready && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == IDX_W'(BLOCKS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_chan.valid) begin
            op_r      <= in_chan.func;
            total_r   <= NUM_W'(in_chan.payload_len) + NUM_W'(BLOCK_BYTES);
            rewound_r <= 1'b0;
            if (in_chan.func == FUNC_PUSH) begin
              state_r <= S_CALC;
            end else if (in_chan.func == FUNC_POP || in_chan.func == FUNC_PEEK) begin
              state_r <= S_FRONT;
            end else begin
              res_ok_r    <= 1'b0;
              res_start_r <= '0;
              res_total_r <= HDR_EMPTY;
              state_r     <= S_RESP;
            end
          end
        end
        S_CALC: begin
          if (op_r != FUNC_PUSH) begin
            state_r <= S_PADV;
          end else if (total_r[TOTAL_W]) begin
            // size does not fit the header field
            res_ok_r    <= 1'b0;
            res_start_r <= '0;
            res_total_r <= HDR_EMPTY;
            state_r     <= S_RESP;
          end else begin
            state_r <= S_FREE;
          end
        end
        S_FREE: begin
          if (need_c >= free_c) begin
            if (rp_r <= wp_r) begin
              free_r  <= CNT_W'(BLOCKS) - CNT_W'(wp_r);
              state_r <= S_WRAPCHK;
            end else begin
              free_r  <= CNT_W'(rp_r - wp_r);
              state_r <= S_FIT;
            end
          end else begin
            state_r <= S_TERM;
          end
        end
        S_WRAPCHK: begin
          state_r <= wrap_go ? S_WMARK : S_FIT;
        end
        S_WMARK: begin
          wp_r    <= '0;
          free_r  <= CNT_W'(rp_r);
          state_r <= S_FIT;
        end
        S_FIT: begin
          if (free_c <= need_c) begin
            res_ok_r    <= 1'b0;
            res_start_r <= '0;
            res_total_r <= total_r[TOTAL_W-1:0];
            state_r     <= S_RESP;
          end else begin
            state_r <= S_TERM;
          end
        end
        S_TERM: begin
          end_r   <= end_idx;
          state_r <= S_HEAD;
        end
        S_HEAD: begin
          res_ok_r    <= 1'b1;
          res_start_r <= wp_r;
          res_total_r <= total_r[TOTAL_W-1:0];
          wp_r        <= end_r;
          free_r      <= CNT_W'(free_c - need_c);
          state_r     <= S_RESP;
        end
        S_FRONT: begin
          state_r <= S_HDR;
        end
        S_HDR: begin
          if (rd_r == HDR_WRAP && !rewound_r) begin
            // follow the marker once, then reread block 0
            rp_r      <= '0;
            rewound_r <= 1'b1;
            state_r   <= S_FRONT;
          end else if (rd_r == HDR_EMPTY) begin
            res_ok_r    <= 1'b0;
            res_start_r <= '0;
            res_total_r <= HDR_EMPTY;
            state_r     <= S_RESP;
          end else begin
            res_ok_r    <= 1'b1;
            res_start_r <= rp_r;
            res_total_r <= rd_r;
            total_r     <= NUM_W'(rd_r);
            state_r     <= (op_r == FUNC_POP) ? S_CALC : S_RESP;
          end
        end
        S_PADV: begin
          rp_r    <= adv_idx;
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= res_ok_r;
            out_start_r <= res_start_wide[START_W-1:0];
            out_total_r <= res_total_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.ok          = out_ok_r;
  assign out_chan.start_block = out_start_r;
  assign out_chan.total_bytes = out_total_r;

  a_pos_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (SUM_W'(wp_r) < SUM_W'(BLOCKS)) && (SUM_W'(rp_r) < SUM_W'(BLOCKS)))
    else $error("ring position outside the ring");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    SUM_W'(wp_r) + SUM_W'(free_r) <= SUM_W'(BLOCKS))
    else $error("free count runs past the end of the ring");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result word appeared outside the response step");

  a_refused_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_start_r == '0))
    else $error("refused or empty result carries a start block");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("word accepted during header clear");

endmodule

[rtl/vlra_blk_div.sv]
// Block count ceil(total / BLOCK_BYTES) by reciprocal multiply, one register stage.
module vlra_blk_div import vlra_pkg::*; #(
  parameter int BLOCK_BYTES = 8
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  total,
  output logic [NEED_W-1:0] need
);

  localparam int    SH     = NUM_W + $clog2(BLOCK_BYTES);
  localparam longint MULT  = ((64'd1 << SH) + BLOCK_BYTES - 1) / BLOCK_BYTES;
  localparam int    PROD_W = SH + NEED_W;

  logic [NUM_W-1:0]  num;
  logic [PROD_W-1:0] prod;
  logic [NEED_W-1:0] need_r;

  // exact for any numerator below 2**NUM_W
  assign num  = total + NUM_W'(BLOCK_BYTES - 1);
  assign prod = PROD_W'(num) * PROD_W'(MULT);

  always_ff @(posedge clk) begin
    if (en) begin
      need_r <= prod[PROD_W-1:SH];
    end
  end

  assign need = need_r;

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
  import vlra_pkg::*;

  localparam int BLOCKS      = 1024;
  localparam int BLOCK_BYTES = 8;
  localparam int N_RAND      = 1924;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_DIR       = 26;

  // selector with no operation behind it
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic               ok;
    logic [START_W-1:0] start_block;
    logic [TOTAL_W-1:0] total_bytes;
  } ring_res_t;

  typedef struct packed {
    logic [1:0]       fn;
    logic [LEN_W-1:0] len;
    logic             typed;
    ring_res_t        res;
  } stim_row_t;

  logic clk;
  logic rst_n;

  vlra_in_if  in_chan ();
  vlra_out_if out_chan ();

  variable_length_ring_allocator_top #(
    .BLOCKS      (BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // shadow copy of the ring bookkeeping
  logic [TOTAL_W-1:0] hdr_mem [BLOCKS];
  int unsigned        wr_blk;
  int unsigned        rd_blk;
  int unsigned        free_blks;

  ring_res_t   ring_q [$];
  stim_row_t   dir_rows [N_DIR];
  int          fails;
  int          gap_pct;
  int          hold_pct;
  int unsigned cyc;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned blocks_for(int unsigned total);
    return (total + BLOCK_BYTES - 1) / BLOCK_BYTES;
  endfunction

  function automatic ring_res_t push_msg(int unsigned len);
    int unsigned total;
    int unsigned need;
    ring_res_t   r;
    r     = '0;
    total = len + BLOCK_BYTES;
    if (total > 65535) return r;
    r.total_bytes = total[TOTAL_W-1:0];
    need = blocks_for(total);
    // cached free count is only trusted while it looks big enough
    if (need >= free_blks) begin
      if (rd_blk <= wr_blk) begin
        free_blks = BLOCKS - wr_blk;
        if (need >= free_blks && rd_blk != 0) begin
          hdr_mem[0] = HDR_EMPTY;
          hdr_mem[wr_blk % BLOCKS] = HDR_WRAP;
          wr_blk = 0;
          free_blks = rd_blk;
        end
      end else begin
        free_blks = rd_blk - wr_blk;
      end
      if (free_blks <= need) return r;
    end
    hdr_mem[(wr_blk + need) % BLOCKS] = HDR_EMPTY;
    hdr_mem[wr_blk % BLOCKS] = total[TOTAL_W-1:0];
    r.ok = 1'b1;
    r.start_block = wr_blk[START_W-1:0];
    wr_blk = (wr_blk + need) % BLOCKS;
    free_blks = free_blks - need;
    return r;
  endfunction

  function automatic ring_res_t read_front(logic take);
    logic [TOTAL_W-1:0] h;
    ring_res_t          r;
    r = '0;
    h = hdr_mem[rd_blk % BLOCKS];
    if (h == HDR_WRAP) begin
      rd_blk = 0;
      h = hdr_mem[0];
    end
    if (h == HDR_EMPTY) return r;
    r.ok = 1'b1;
    r.start_block = rd_blk[START_W-1:0];
    r.total_bytes = h;
    if (take) rd_blk = (rd_blk + blocks_for(h)) % BLOCKS;
    return r;
  endfunction

  function automatic ring_res_t ring_step(logic [1:0] fn, logic [LEN_W-1:0] len);
    case (fn)
      FUNC_PUSH: return push_msg(len);
      FUNC_POP:  return read_front(1'b1);
      FUNC_PEEK: return read_front(1'b0);
      default:   return '0;
    endcase
  endfunction

  task automatic send_word(logic [1:0] fn, logic [LEN_W-1:0] len, logic typed,
                           ring_res_t typed_res);
    ring_res_t r;
    while ($urandom_range(99) < gap_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.func        <= fn;
    in_chan.payload_len <= len;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    r = ring_step(fn, len);
    ring_q.push_back(typed ? typed_res : r);
  endtask

  task automatic pick_word(int mode, output logic [1:0] fn, output logic [LEN_W-1:0] len);
    int unsigned p;
    int unsigned push_lim;
    int unsigned pop_lim;
    push_lim = (mode == 0) ? 70 : (mode == 1) ? 20 : 45;
    pop_lim  = (mode == 1) ? 80 : 85;
    p = $urandom_range(99);
    if (p < push_lim)     fn = FUNC_PUSH;
    else if (p < pop_lim) fn = FUNC_POP;
    else                  fn = FUNC_PEEK;
    if ($urandom_range(99) == 0) fn = FUNC_UNUSED;
    p = $urandom_range(99);
    if (p < 70)      len = LEN_W'($urandom_range(120));
    else if (p < 85) len = LEN_W'($urandom_range(1500, 121));
    else if (p < 92) len = LEN_W'($urandom_range(9000, 1501));
    else if (p < 97) len = LEN_W'($urandom_range(65527));
    else             len = LEN_W'($urandom_range(65535, 65528));
  endtask

  task automatic drain_wait();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (ring_q.size() != 0) @(posedge clk);
  endtask

  // sink side: random stalls
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= ($urandom_range(99) >= hold_pct);
    end
  end

  always @(posedge clk) begin
    ring_res_t got;
    ring_res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.ok, out_chan.start_block, out_chan.total_bytes};
      if (ring_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected word: ok=%0d start=%0d total=%0d",
                   got.ok, got.start_block, got.total_bytes);
      end else begin
        want = ring_q.pop_front();
        if (got.ok !== want.ok || got.start_block !== want.start_block ||
            got.total_bytes !== want.total_bytes) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: exp ok=%0d start=%0d total=%0d, got ok=%0d start=%0d total=%0d",
                     want.ok, want.start_block, want.total_bytes,
                     got.ok, got.start_block, got.total_bytes);
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int               mode;
    logic [1:0]       fn;
    logic [LEN_W-1:0] len;
    in_chan.valid       <= 1'b0;
    in_chan.func        <= FUNC_PUSH;
    in_chan.payload_len <= '0;
    rst_n <= 1'b0;
    gap_pct  = 9;
    hold_pct = 9;
    mode     = 2;
    foreach (hdr_mem[i]) hdr_mem[i] = HDR_EMPTY;
    wr_blk    = 0;
    rd_blk    = 0;
    free_blks = BLOCKS;

    dir_rows = '{
      '{FUNC_PEEK,   16'd0,     1'b1, '{1'b0, 10'd0, 16'd0}},      // empty after reset
      '{FUNC_POP,    16'd0,     1'b1, '{1'b0, 10'd0, 16'd0}},
      '{FUNC_PUSH,   16'd65535, 1'b1, '{1'b0, 10'd0, 16'd0}},      // oversized
      '{FUNC_PUSH,   16'd65528, 1'b1, '{1'b0, 10'd0, 16'd0}},
      '{FUNC_PUSH,   16'd65527, 1'b1, '{1'b0, 10'd0, 16'd65535}},  // largest, never fits
      '{FUNC_PUSH,   16'd0,     1'b1, '{1'b1, 10'd0, 16'd8}},
      '{FUNC_UNUSED, 16'd0,     1'b1, '{1'b0, 10'd0, 16'd0}},
      '{FUNC_PEEK,   16'd0,     1'b1, '{1'b1, 10'd0, 16'd8}},
      '{FUNC_POP,    16'd0,     1'b1, '{1'b1, 10'd0, 16'd8}},
      '{FUNC_POP,    16'd0,     1'b1, '{1'b0, 10'd0, 16'd0}},      // hits terminator
      '{FUNC_PUSH,   16'd1,     1'b0, '0},
      '{FUNC_PUSH,   16'd7,     1'b0, '0},
      '{FUNC_PUSH,   16'd8000,  1'b0, '0},
      '{FUNC_PUSH,   16'd200,   1'b0, '0},                          // wraps, then refused
      '{FUNC_PEEK,   16'd0,     1'b0, '0},
      '{FUNC_POP,    16'd0,     1'b0, '0},
      '{FUNC_POP,    16'd0,     1'b0, '0},
      '{FUNC_POP,    16'd0,     1'b0, '0},
      '{FUNC_POP,    16'd0,     1'b0, '0},                          // wrap marker, empty
      '{FUNC_PUSH,   16'd16,    1'b0, '0},
      '{FUNC_PUSH,   16'd8,     1'b0, '0},
      '{FUNC_PEEK,   16'd0,     1'b0, '0},
      '{FUNC_POP,    16'd0,     1'b0, '0},
      '{FUNC_POP,    16'd0,     1'b0, '0},
      '{FUNC_PUSH,   16'd43690, 1'b0, '0},
      '{FUNC_PUSH,   16'd21845, 1'b0, '0}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_word(dir_rows[i].fn, dir_rows[i].len, dir_rows[i].typed, dir_rows[i].res);
    drain_wait();

    for (int i = 0; i < N_RAND; i++) begin
      // bursts lean towards filling or draining so the ring wraps often
      if (i % 40 == 0) mode = $urandom_range(2);
      if (i == 700) begin
        gap_pct  = 0;
        hold_pct = 0;
      end
      if (i == 1000) begin
        gap_pct  = 9;
        hold_pct = 9;
      end
      if (i == 1300) drain_wait();
      pick_word(mode, fn, len);
      send_word(fn, len, 1'b0, '0);
    end

    drain_wait();
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[variable_length_ring_allocator_top.f]
rtl/vlra_pkg.sv
rtl/vlra_if.sv
rtl/vlra_blk_div.sv
rtl/variable_length_ring_allocator_top.sv
test/tb.sv
